@@ hw/rtl/trie_command_table_macros.svh @@
// Assertion helpers shared by the checker.
`ifndef TRIE_COMMAND_TABLE_MACROS_SVH
`define TRIE_COMMAND_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tct assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tct assertion failed");

`endif

@@ hw/rtl/tct_pkg.sv @@
`timescale 1ns / 1ps
package tct_pkg;

    localparam int NODE_COUNT = 256;
    localparam int NODE_AW    = 8;
    localparam int CNT_W      = 9;
    localparam int LEN_W      = 6;
    localparam int CHAR_W     = 7;
    localparam int CMD_W      = 8;
    localparam int BL_W       = 7;
    localparam int FOUND_W    = 9;
    localparam int LINK_W     = NODE_AW + 1;

    localparam logic [LEN_W-1:0]   LEN_FULL   = 6'd63;
    localparam logic [BL_W-1:0]    BL_RESET   = 7'd64;
    localparam logic [BL_W-1:0]    BL_MAX     = 7'd64;
    localparam logic [FOUND_W-1:0] FOUND_NONE = 9'h1FF;
    localparam logic [7:0]         CHAR_LO    = 8'h20;
    localparam logic [7:0]         CHAR_HI    = 8'h7E;

    // Operation codes.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_AUTO   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Result word kinds built by the datapath.
    localparam logic [2:0] RES_INVALID = 3'd0;
    localparam logic [2:0] RES_OK      = 3'd1;
    localparam logic [2:0] RES_FULL    = 3'd2;
    localparam logic [2:0] RES_LOOKUP  = 3'd3;
    localparam logic [2:0] RES_ABS_L   = 3'd4;
    localparam logic [2:0] RES_ABS_A   = 3'd5;
    localparam logic [2:0] RES_CHAR    = 3'd6;
    localparam logic [2:0] RES_FINAL   = 3'd7;

    // Kind of link that joins new nodes to the trie.
    localparam logic [1:0] LK_NONE = 2'd0;
    localparam logic [1:0] LK_SIB  = 2'd1;
    localparam logic [1:0] LK_KID  = 2'd2;

    typedef struct packed {
        logic       push;
        logic       latch;
        logic       str_clr;
        logic       n_zero;
        logic       n_sib;
        logic       n_kid;
        logic       pos_zero;
        logic       pos_inc;
        logic       i_load;
        logic       i_inc;
        logic       lk_load;
        logic [1:0] lk;
        logic       link_wr;
        logic       node_wr;
        logic       cmd_wr;
        logic       emit;
        logic [2:0] res;
        logic       more;
    } tct_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       bad;
        logic       count_zero;
        logic       ch_eq;
        logic       sib_v;
        logic       kid_v;
        logic       pos_last;
        logic       fits;
        logic       len_ge_lim;
        logic       i_next_lt_lim;
        logic       slot_free;
    } tct_sts_t;

endpackage

@@ hw/rtl/tct_datapath.sv @@
`timescale 1ns / 1ps
module tct_datapath import tct_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  tct_cmd_t         cmd,
    output tct_sts_t         sts,
    input  logic [1:0]       in_mode,
    input  logic [7:0]       in_char,
    input  logic [CMD_W-1:0] in_cmd,
    input  logic             cfg_wr_en,
    input  logic [BL_W-1:0]  cfg_wr_data,
    input  logic             m_ready,
    output logic             m_valid,
    output logic [1:0]       m_user,
    output logic [23:0]      m_data,
    output logic             m_last
);

    logic [CHAR_W-1:0] buf_mem [0:(1 << LEN_W)-1];
    logic [CHAR_W-1:0] ch_mem  [0:NODE_COUNT-1];
    logic [LINK_W-1:0] cmd_mem [0:NODE_COUNT-1];
    logic [LINK_W-1:0] sib_mem [0:NODE_COUNT-1];
    logic [LINK_W-1:0] kid_mem [0:NODE_COUNT-1];

    logic [LEN_W-1:0]   len_reg;
    logic               inval_reg;
    logic [1:0]         mode_reg;
    logic [CMD_W-1:0]   cmdv_reg;
    logic [BL_W-1:0]    bl_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [NODE_AW-1:0] n_reg;
    logic [LEN_W-1:0]   pos_reg;
    logic [LEN_W-1:0]   i_reg;
    logic [1:0]         lk_reg;
    logic [CHAR_W-1:0]  rd_buf_reg;
    logic [CHAR_W-1:0]  rd_ch_reg;
    logic [LINK_W-1:0]  rd_cmd_reg;
    logic [LINK_W-1:0]  rd_sib_reg;
    logic [LINK_W-1:0]  rd_kid_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [FOUND_W-1:0] out_found_reg;
    logic               out_cv_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [LEN_W-1:0]   out_nl_reg;
    logic               out_more_reg;
    logic               out_last_reg;

    logic               slot_free;
    logic               char_bad;
    logic [BL_W-1:0]    bl_sat;
    logic [BL_W-1:0]    lim;
    logic [NODE_AW-1:0] new_idx;
    logic               pos_last;

    logic               cmd_we;
    logic [NODE_AW-1:0] cmd_wa;
    logic [LINK_W-1:0]  cmd_wd;
    logic               sib_we;
    logic [NODE_AW-1:0] sib_wa;
    logic [LINK_W-1:0]  sib_wd;
    logic               kid_we;
    logic [NODE_AW-1:0] kid_wa;
    logic [LINK_W-1:0]  kid_wd;

    logic [1:0]         res_status;
    logic [FOUND_W-1:0] res_found;
    logic               res_cv;
    logic [CHAR_W-1:0]  res_char;
    logic [LEN_W-1:0]   res_nl;
    logic               res_more;
    logic               res_last;

    assign slot_free = !out_valid_reg || m_ready;
    assign char_bad  = (in_char < CHAR_LO) || (in_char > CHAR_HI);
    assign bl_sat    = (bl_reg > BL_MAX) ? BL_MAX : bl_reg;
    assign lim       = (bl_sat == '0) ? '0 : bl_sat - 7'd1;
    assign new_idx   = count_reg[NODE_AW-1:0];
    assign pos_last  = ({1'b0, pos_reg} + 7'd1) == {1'b0, len_reg};

    // Status towards the controller.
    always_comb begin
        sts.mode          = mode_reg;
        sts.bad           = inval_reg || (mode_reg == MODE_NONE) ||
                            (((mode_reg == MODE_LOOKUP) || (mode_reg == MODE_AUTO)) &&
                             ({1'b0, len_reg} > lim));
        sts.count_zero    = (count_reg == '0);
        sts.ch_eq         = (rd_ch_reg == rd_buf_reg);
        sts.sib_v         = rd_sib_reg[LINK_W-1];
        sts.kid_v         = rd_kid_reg[LINK_W-1];
        sts.pos_last      = pos_last;
        sts.fits          = {3'b000, len_reg - pos_reg} <= (CNT_W'(NODE_COUNT) - count_reg);
        sts.len_ge_lim    = {1'b0, len_reg} >= lim;
        sts.i_next_lt_lim = ({1'b0, i_reg} + 7'd1) < lim;
        sts.slot_free     = slot_free;
    end

    // Write ports of the node store.
    always_comb begin
        cmd_we = cmd.node_wr || cmd.cmd_wr;
        cmd_wa = cmd.node_wr ? new_idx : n_reg;
        cmd_wd = (cmd.node_wr && !pos_last) ? '0 : {1'b1, cmdv_reg};
        sib_we = cmd.node_wr || (cmd.link_wr && (lk_reg == LK_SIB));
        sib_wa = cmd.node_wr ? new_idx : n_reg;
        sib_wd = cmd.node_wr ? '0 : {1'b1, new_idx};
        kid_we = cmd.node_wr || (cmd.link_wr && (lk_reg == LK_KID));
        kid_wa = cmd.node_wr ? new_idx : n_reg;
        if (cmd.node_wr) begin
            kid_wd = pos_last ? '0 : {1'b1, new_idx + 8'd1};
        end else begin
            kid_wd = {1'b1, new_idx};
        end
    end

    // String buffer: written at the fill level, read at the walk position.
    always_ff @(posedge aclk) begin
        if (cmd.push && (len_reg != LEN_FULL)) begin
            buf_mem[len_reg] <= in_char[CHAR_W-1:0];
        end
        rd_buf_reg <= buf_mem[pos_reg];
    end

    // Node store arrays with registered reads at the current node.
    always_ff @(posedge aclk) begin
        if (cmd.node_wr) begin
            ch_mem[new_idx] <= rd_buf_reg;
        end
        if (cmd_we) begin
            cmd_mem[cmd_wa] <= cmd_wd;
        end
        if (sib_we) begin
            sib_mem[sib_wa] <= sib_wd;
        end
        if (kid_we) begin
            kid_mem[kid_wa] <= kid_wd;
        end
        rd_ch_reg  <= ch_mem[n_reg];
        rd_cmd_reg <= cmd_mem[n_reg];
        rd_sib_reg <= sib_mem[n_reg];
        rd_kid_reg <= kid_mem[n_reg];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            inval_reg     <= 1'b0;
            bl_reg        <= BL_RESET;
            count_reg     <= '0;
            lk_reg        <= LK_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                bl_reg <= cfg_wr_data;
            end
            if (cmd.str_clr) begin
                len_reg   <= '0;
                inval_reg <= 1'b0;
            end else if (cmd.push) begin
                if (char_bad || (len_reg == LEN_FULL)) begin
                    inval_reg <= 1'b1;
                end
                if (len_reg != LEN_FULL) begin
                    len_reg <= len_reg + 6'd1;
                end
            end
            if (cmd.node_wr) begin
                count_reg <= count_reg + 9'd1;
            end
            if (cmd.lk_load) begin
                lk_reg <= cmd.lk;
            end
            if (slot_free) begin
                out_valid_reg <= cmd.emit;
            end
        end
    end

    // Walk registers and the latched operation.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            mode_reg <= in_mode;
            cmdv_reg <= in_cmd;
        end
        if (cmd.n_zero) begin
            n_reg <= '0;
        end else if (cmd.n_sib) begin
            n_reg <= rd_sib_reg[NODE_AW-1:0];
        end else if (cmd.n_kid) begin
            n_reg <= rd_kid_reg[NODE_AW-1:0];
        end
        if (cmd.pos_zero) begin
            pos_reg <= '0;
        end else if (cmd.pos_inc) begin
            pos_reg <= pos_reg + 6'd1;
        end
        if (cmd.i_load) begin
            i_reg <= len_reg;
        end else if (cmd.i_inc) begin
            i_reg <= i_reg + 6'd1;
        end
    end

    // Result word formation.
    always_comb begin
        res_status = ST_OK;
        res_found  = '0;
        res_cv     = 1'b0;
        res_char   = '0;
        res_nl     = '0;
        res_more   = 1'b0;
        res_last   = 1'b1;
        case (cmd.res)
            RES_INVALID: begin
                res_status = ST_INVALID;
                res_found  = FOUND_NONE;
            end
            RES_FULL: begin
                res_status = ST_FULL;
            end
            RES_LOOKUP: begin
                if (rd_cmd_reg[LINK_W-1]) begin
                    res_found = {1'b0, rd_cmd_reg[CMD_W-1:0]};
                end else begin
                    res_status = ST_NOT_FOUND;
                    res_found  = FOUND_NONE;
                end
            end
            RES_ABS_L: begin
                res_status = ST_NOT_FOUND;
                res_found  = FOUND_NONE;
            end
            RES_ABS_A: begin
                res_status = ST_NOT_FOUND;
            end
            RES_CHAR: begin
                res_cv   = 1'b1;
                res_char = rd_ch_reg;
                res_nl   = i_reg + 6'd1;
                res_last = 1'b0;
            end
            RES_FINAL: begin
                res_nl   = i_reg;
                res_more = cmd.more;
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    // Output register: holds a word while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (slot_free && cmd.emit) begin
            out_status_reg <= res_status;
            out_found_reg  <= res_found;
            out_cv_reg     <= res_cv;
            out_char_reg   <= res_char;
            out_nl_reg     <= res_nl;
            out_more_reg   <= res_more;
            out_last_reg   <= res_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_user  = out_status_reg;
    assign m_data  = {out_more_reg, out_nl_reg, out_char_reg, out_cv_reg, out_found_reg};
    assign m_last  = out_last_reg;

endmodule

@@ hw/rtl/tct_ctrl.sv @@
`timescale 1ns / 1ps
module tct_ctrl import tct_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_last,
    output logic     s_ready,
    input  tct_sts_t sts,
    output tct_cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_READ     = 4'd2;
    localparam logic [3:0] S_CMP      = 4'd3;
    localparam logic [3:0] S_CHECK    = 4'd4;
    localparam logic [3:0] S_ALLOC_RD = 4'd5;
    localparam logic [3:0] S_ALLOC_WR = 4'd6;
    localparam logic [3:0] S_AREAD    = 4'd7;
    localparam logic [3:0] S_ACMP     = 4'd8;
    localparam logic [3:0] S_AFIN     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] absent_res;

    assign absent_res = (sts.mode == MODE_LOOKUP) ? RES_ABS_L : RES_ABS_A;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.push = 1'b1;
                    if (s_last) begin
                        cmd.latch  = 1'b1;
                        state_next = S_START;
                    end
                end
            end
            S_START: begin
                if (sts.slot_free) begin
                    cmd.n_zero   = 1'b1;
                    cmd.pos_zero = 1'b1;
                    if (sts.bad) begin
                        cmd.emit    = 1'b1;
                        cmd.res     = RES_INVALID;
                        cmd.str_clr = 1'b1;
                        state_next  = S_IDLE;
                    end else if (sts.count_zero) begin
                        if (sts.mode == MODE_INSERT) begin
                            cmd.lk_load = 1'b1;
                            cmd.lk      = LK_NONE;
                            state_next  = S_CHECK;
                        end else begin
                            cmd.emit    = 1'b1;
                            cmd.res     = absent_res;
                            cmd.str_clr = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (sts.slot_free) begin
                    if (sts.ch_eq && sts.pos_last) begin
                        // The string ends on this node.
                        if (sts.mode == MODE_INSERT) begin
                            cmd.cmd_wr  = 1'b1;
                            cmd.emit    = 1'b1;
                            cmd.res     = RES_OK;
                            cmd.str_clr = 1'b1;
                            state_next  = S_IDLE;
                        end else if (sts.mode == MODE_LOOKUP) begin
                            cmd.emit    = 1'b1;
                            cmd.res     = RES_LOOKUP;
                            cmd.str_clr = 1'b1;
                            state_next  = S_IDLE;
                        end else if (!sts.kid_v || sts.len_ge_lim) begin
                            cmd.emit    = 1'b1;
                            cmd.res     = RES_OK;
                            cmd.str_clr = 1'b1;
                            state_next  = S_IDLE;
                        end else begin
                            cmd.n_kid  = 1'b1;
                            cmd.i_load = 1'b1;
                            state_next = S_AREAD;
                        end
                    end else if (sts.ch_eq) begin
                        // Descend a level.
                        cmd.pos_inc = 1'b1;
                        if (sts.kid_v) begin
                            cmd.n_kid  = 1'b1;
                            state_next = S_READ;
                        end else if (sts.mode == MODE_INSERT) begin
                            cmd.lk_load = 1'b1;
                            cmd.lk      = LK_KID;
                            state_next  = S_CHECK;
                        end else begin
                            cmd.emit    = 1'b1;
                            cmd.res     = absent_res;
                            cmd.str_clr = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end else if (sts.sib_v) begin
                        cmd.n_sib  = 1'b1;
                        state_next = S_READ;
                    end else if (sts.mode == MODE_INSERT) begin
                        cmd.lk_load = 1'b1;
                        cmd.lk      = LK_SIB;
                        state_next  = S_CHECK;
                    end else begin
                        cmd.emit    = 1'b1;
                        cmd.res     = absent_res;
                        cmd.str_clr = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_CHECK: begin
                if (sts.slot_free) begin
                    if (!sts.fits) begin
                        cmd.emit    = 1'b1;
                        cmd.res     = RES_FULL;
                        cmd.str_clr = 1'b1;
                        state_next  = S_IDLE;
                    end else begin
                        cmd.link_wr = 1'b1;
                        state_next  = S_ALLOC_RD;
                    end
                end
            end
            S_ALLOC_RD: begin
                state_next = S_ALLOC_WR;
            end
            S_ALLOC_WR: begin
                if (sts.slot_free) begin
                    cmd.node_wr = 1'b1;
                    cmd.pos_inc = 1'b1;
                    if (sts.pos_last) begin
                        cmd.emit    = 1'b1;
                        cmd.res     = RES_OK;
                        cmd.str_clr = 1'b1;
                        state_next  = S_IDLE;
                    end else begin
                        state_next = S_ALLOC_RD;
                    end
                end
            end
            S_AREAD: begin
                state_next = S_ACMP;
            end
            S_ACMP: begin
                if (sts.slot_free) begin
                    cmd.emit = 1'b1;
                    if (sts.sib_v) begin
                        cmd.res     = RES_FINAL;
                        cmd.more    = 1'b1;
                        cmd.str_clr = 1'b1;
                        state_next  = S_IDLE;
                    end else begin
                        cmd.res   = RES_CHAR;
                        cmd.i_inc = 1'b1;
                        if (sts.kid_v && sts.i_next_lt_lim) begin
                            cmd.n_kid  = 1'b1;
                            state_next = S_AREAD;
                        end else begin
                            state_next = S_AFIN;
                        end
                    end
                end
            end
            S_AFIN: begin
                if (sts.slot_free) begin
                    cmd.emit    = 1'b1;
                    cmd.res     = RES_FINAL;
                    cmd.more    = sts.kid_v;
                    cmd.str_clr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/trie_command_table.sv @@
`timescale 1ns / 1ps
// Command table kept as a first-child / next-sibling trie.
// Input channel s_axis: one character per word; tlast marks the final
// character and runs the operation named by tuser (insert, lookup,
// autocomplete). Result channel m_axis: one word per insert or lookup, and
// for autocomplete one word per added character followed by a final word
// with tlast high. cfg_wr_en/cfg_wr_data write buffer_length; the user must
// write it only while idle, as the block does not enforce this. Characters
// that are not last are taken one per cycle while idle. After the last word
// the controller walks the node store node by node through its registered
// read port, then allocates new nodes on insert or emits added characters
// on autocomplete. The input is not ready while an operation runs.
// Results sit in an output register; when the receiver stalls, the walk
// waits with the pending word, and the input stays ready between strings
// even while the last result waits to be taken.
// A synchronous low aresetn empties the trie and the string buffer and sets
// buffer_length to 64; no clearing pass is needed.
module trie_command_table import tct_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // char_in [7:0], cmd_index [15:8]
    input  logic [1:0]  s_axis_tuser,   // mode [1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found_cmd [8:0], char_valid [9], out_char [16:10], new_length [22:17],
    // more_choices [23]
    output logic [23:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // status [1:0]
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data
);

    tct_cmd_t cmd;
    tct_sts_t sts;

    tct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_last  (s_axis_tlast),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tct_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_mode     (s_axis_tuser),
        .in_char     (s_axis_tdata[7:0]),
        .in_cmd      (s_axis_tdata[15:8]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_ready     (m_axis_tready),
        .m_valid     (m_axis_tvalid),
        .m_user      (m_axis_tuser),
        .m_data      (m_axis_tdata),
        .m_last      (m_axis_tlast)
    );

endmodule

@@ hw/rtl/tct_checker.sv @@
`timescale 1ns / 1ps
`include "trie_command_table_macros.svh"
module tct_checker import tct_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result word holds.
    `TCT_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // Reset leaves no result pending.
    `TCT_ASSERT_NEXT(a_reset, aclk, 1'b1, !aresetn, !m_axis_tvalid)

    // The walk starts after the final character, so input stops.
    `TCT_ASSERT_NEXT(a_busy, aclk, aresetn, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

    // A character word is never the final word of an operation.
    `TCT_ASSERT_SAME(a_char, aclk, aresetn, m_axis_tvalid && m_axis_tdata[9], !m_axis_tlast && (m_axis_tuser == ST_OK))

    // An invalid string answers with a single word and no command.
    `TCT_ASSERT_SAME(a_inval, aclk, aresetn, m_axis_tvalid && (m_axis_tuser == ST_INVALID), m_axis_tlast && (m_axis_tdata[8:0] == FOUND_NONE))

endmodule

bind trie_command_table tct_checker u_tct_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ verif/tb_trie_command_table.sv @@
`timescale 1ns / 1ps
module tb_trie_command_table;
    import tct_pkg::*;

    // One result word as seen on the master side.
    typedef struct packed {
        logic [1:0] status;
        logic [8:0] found;
        logic       cvalid;
        logic [6:0] ochar;
        logic [5:0] nlen;
        logic       more;
        logic       lastw;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;

    // Shadow copy of the trie and the string collector.
    logic [6:0] trie_char [NODE_COUNT];
    int         trie_cmd  [NODE_COUNT];
    int         trie_sib  [NODE_COUNT];
    int         trie_kid  [NODE_COUNT];
    int         trie_used;
    logic [6:0] str_chars [64];
    int         str_len;
    bit         str_bad;
    int         buf_limit;

    result_t    pending_results[$];
    int         errors = 0;
    int         idle_cycles = 0;
    int         hold_request = 0;
    int         hold_left = 0;
    int         gap_left = 0;
    bit         steady = 1'b0;

    trie_command_table i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit node_live(int n);
        return n >= 0 && n < trie_used;
    endfunction

    function automatic result_t make_result(logic [1:0] st, int found, bit cv,
                                            logic [6:0] oc, int nl, bit more,
                                            bit lst);
        result_t r;
        r.status = st;
        r.found  = found[8:0];
        r.cvalid = cv;
        r.ochar  = oc;
        r.nlen   = nl[5:0];
        r.more   = more;
        r.lastw  = lst;
        return r;
    endfunction

    // Search one sibling level for a character; tail gets the last node seen.
    function automatic int scan_level(int start, logic [6:0] c, output int tail);
        int n;
        n = start;
        tail = -1;
        while (node_live(n)) begin
            if (trie_char[n] == c) return n;
            tail = n;
            n = trie_sib[n];
        end
        return -1;
    endfunction

    // Node that ends the collected string, or -1.
    function automatic int find_string_end();
        int n, m, t;
        n = 0;
        if (trie_used == 0 || str_len == 0) return -1;
        for (int p = 0; p < str_len; p++) begin
            if (!node_live(n)) return -1;
            m = scan_level(n, str_chars[p], t);
            if (m < 0) return -1;
            if (p + 1 == str_len) return m;
            n = trie_kid[m];
        end
        return -1;
    endfunction

    function automatic logic [1:0] insert_string(int cmd);
        int attach, n, m, t, prev, pos, idx;
        logic [1:0] kind;
        attach = -1;
        n = 0;
        pos = 0;
        kind = LK_NONE;
        if (trie_used > 0) begin
            forever begin
                if (!node_live(n)) return ST_INVALID;
                m = scan_level(n, str_chars[pos], t);
                if (m < 0) begin
                    if (t < 0) return ST_INVALID;
                    attach = t;
                    kind = LK_SIB;
                    break;
                end
                if (pos + 1 >= str_len) begin
                    trie_cmd[m] = cmd;
                    return ST_OK;
                end
                pos++;
                if (trie_kid[m] < 0) begin
                    attach = m;
                    kind = LK_KID;
                    break;
                end
                n = trie_kid[m];
            end
        end
        if (str_len - pos > NODE_COUNT - trie_used) return ST_FULL;
        prev = attach;
        for (int i = pos; i < str_len; i++) begin
            idx = trie_used++;
            trie_char[idx] = str_chars[i];
            trie_cmd[idx] = -1;
            trie_sib[idx] = -1;
            trie_kid[idx] = -1;
            if (i == pos) begin
                if (kind == LK_SIB) trie_sib[attach] = idx;
                else if (kind == LK_KID) trie_kid[attach] = idx;
            end else begin
                trie_kid[prev] = idx;
            end
            prev = idx;
        end
        if (node_live(prev)) trie_cmd[prev] = cmd;
        return ST_OK;
    endfunction

    function automatic void complete_string(int lim);
        int e, n, i, added;
        e = find_string_end();
        i = str_len;
        added = 0;
        if (e < 0) begin
            pending_results.push_back(make_result(ST_NOT_FOUND, 0, 0, 0, 0, 0, 1));
            return;
        end
        n = trie_kid[e];
        if (!node_live(n) || i >= lim) begin
            pending_results.push_back(make_result(ST_OK, 0, 0, 0, 0, 0, 1));
            return;
        end
        while (node_live(n) && i < lim && added < 63) begin
            if (trie_sib[n] >= 0) break;
            i++;
            added++;
            pending_results.push_back(make_result(ST_OK, 0, 1, trie_char[n], i, 0, 0));
            n = trie_kid[n];
        end
        pending_results.push_back(make_result(ST_OK, 0, 0, 0, i, node_live(n), 1));
    endfunction

    // Expected results caused by one accepted input word.
    function automatic void predict_word(logic [1:0] mode, logic [7:0] c, bit lst,
                                         logic [7:0] cmd);
        int b, lim, e, f;
        bit bad;
        if (c < CHAR_LO || c > CHAR_HI) str_bad = 1'b1;
        if (str_len >= 63) str_bad = 1'b1;
        else str_chars[str_len++] = c[6:0];
        if (!lst) return;
        b = buf_limit > 64 ? 64 : buf_limit;
        lim = b > 0 ? b - 1 : 0;
        bad = str_bad || str_len == 0 || mode == MODE_NONE;
        if ((mode == MODE_LOOKUP || mode == MODE_AUTO) && str_len > lim) bad = 1'b1;
        if (bad) begin
            pending_results.push_back(make_result(ST_INVALID, -1, 0, 0, 0, 0, 1));
        end else if (mode == MODE_INSERT) begin
            pending_results.push_back(make_result(insert_string(cmd), 0, 0, 0, 0, 0, 1));
        end else if (mode == MODE_LOOKUP) begin
            e = find_string_end();
            f = e >= 0 ? trie_cmd[e] : -1;
            pending_results.push_back(make_result(f >= 0 ? ST_OK : ST_NOT_FOUND, f,
                                                  0, 0, 0, 0, 1));
        end else begin
            complete_string(lim);
        end
        str_len = 0;
        str_bad = 1'b0;
    endfunction

    // Offer one word and wait until it is taken; valid is left high.
    task automatic send_word(logic [1:0] mode, logic [7:0] c, bit lst, logic [7:0] cmd);
        int gap;
        bit rdy;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cmd, c};
        s_axis_tuser  <= mode;
        s_axis_tlast  <= lst;
        do begin
            @(negedge aclk);
            rdy = s_axis_tready;
            @(posedge aclk);
        end while (!rdy);
        predict_word(mode, c, lst, cmd);
    endtask

    task automatic send_string(logic [1:0] mode, string s, logic [7:0] cmd);
        for (int i = 0; i < s.len(); i++)
            send_word(mode, s[i], i == s.len() - 1, cmd);
    endtask

    // Wait for every expected word, then let the block settle before a write.
    task automatic drain();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_buffer_length(logic [6:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        buf_limit = value;
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            m_axis_tready <= 1'b0;
        end else begin
            gap_left = pick_gap();
            m_axis_tready <= (gap_left == 0);
        end
    end

    // Compare each word taken at the coming edge with the oldest expectation.
    always @(negedge aclk) begin
        result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = make_result(m_axis_tuser, int'(m_axis_tdata[8:0]), m_axis_tdata[9],
                              m_axis_tdata[16:10], int'(m_axis_tdata[22:17]),
                              m_axis_tdata[23], m_axis_tlast);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word %h", $realtime, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.found !== want.found ||
                    got.cvalid !== want.cvalid || got.ochar !== want.ochar ||
                    got.nlen !== want.nlen || got.more !== want.more ||
                    got.lastw !== want.lastw) begin
                    $display("%0t: mismatch expected st=%0d fc=%h cv=%b ch=%h nl=%0d mc=%b l=%b",
                             $realtime, want.status, want.found, want.cvalid, want.ochar,
                             want.nlen, want.more, want.lastw);
                    $display("%0t:          actual   st=%0d fc=%h cv=%b ch=%h nl=%0d mc=%b l=%b",
                             $realtime, got.status, got.found, got.cvalid, got.ochar,
                             got.nlen, got.more, got.lastw);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(negedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 20000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic string random_word(int len, int span);
        string s;
        s = "";
        for (int i = 0; i < len; i++)
            s = {s, string'(8'("a" + $urandom_range(0, span - 1)))};
        return s;
    endfunction

    // Empty trie, every operation, bad characters, bad modes and overwrite.
    task automatic test_directed();
        send_string(MODE_LOOKUP, "go", 8'd0);
        send_string(MODE_AUTO, "g", 8'd0);
        send_string(MODE_INSERT, "go", 8'd5);
        send_string(MODE_LOOKUP, "go", 8'd0);
        send_string(MODE_LOOKUP, "g", 8'd0);
        send_string(MODE_LOOKUP, "x", 8'd0);
        send_string(MODE_AUTO, "g", 8'd0);
        send_string(MODE_INSERT, "gone", 8'd255);
        send_string(MODE_AUTO, "go", 8'd0);
        send_string(MODE_INSERT, "go", 8'd0);
        send_string(MODE_LOOKUP, "go", 8'd0);
        send_string(MODE_INSERT, "gate", 8'd9);
        send_string(MODE_AUTO, "g", 8'd0);
        send_string(MODE_INSERT, " ~", 8'd1);
        send_string(MODE_LOOKUP, " ~", 8'd0);
        send_word(MODE_INSERT, 8'h1F, 1'b1, 8'd3);
        send_word(MODE_LOOKUP, 8'h7F, 1'b1, 8'd0);
        send_word(MODE_AUTO, 8'h61, 1'b0, 8'd0);
        send_word(MODE_AUTO, 8'hFF, 1'b1, 8'd0);
        send_word(MODE_INSERT, 8'h00, 1'b1, 8'hAA);
        send_string(MODE_NONE, "go", 8'd0);
        // Sixty-four characters: longer than the string buffer allows.
        for (int i = 0; i < 64; i++) send_word(MODE_INSERT, "q", i == 63, 8'd7);
    endtask

    // Extremes of buffer_length, including zero and values above the maximum.
    task automatic test_buffer_length();
        write_buffer_length(7'd2);
        send_string(MODE_LOOKUP, "g", 8'd0);
        send_string(MODE_LOOKUP, "go", 8'd0);
        send_string(MODE_AUTO, "g", 8'd0);
        write_buffer_length(7'd0);
        send_string(MODE_LOOKUP, "g", 8'd0);
        write_buffer_length(7'd1);
        send_string(MODE_AUTO, "g", 8'd0);
        write_buffer_length(7'd4);
        send_string(MODE_AUTO, "go", 8'd0);
        write_buffer_length(7'd127);
        // A long single chain lets autocomplete run to the buffer's end.
        for (int i = 0; i < 63; i++) send_word(MODE_INSERT, "z", i == 62, 8'd4);
        send_string(MODE_AUTO, "z", 8'd0);
        write_buffer_length(7'd20);
        send_string(MODE_AUTO, "zz", 8'd0);
        write_buffer_length(7'd64);
    endtask

    // Random strings over a small alphabet, with some broken ones.
    task automatic test_random(int items);
        int sent, len, r, held;
        logic [1:0] mode;
        string s;
        sent = 0;
        held = 0;
        while (sent < items) begin
            r = $urandom_range(0, 99);
            mode = r < 40 ? MODE_INSERT : r < 70 ? MODE_LOOKUP : r < 97 ? MODE_AUTO : MODE_NONE;
            len = $urandom_range(0, 9) == 0 ? $urandom_range(7, 12) : $urandom_range(1, 5);
            s = random_word(len, $urandom_range(2, 4));
            if (!held && sent > items / 2) begin
                held = 1;
                hold_request = 3000;
            end
            steady = (sent > items / 4 && sent < items / 3);
            if ($urandom_range(0, 19) == 0) begin
                for (int i = 0; i < len - 1; i++) send_word(mode, s[i], 1'b0, 8'($urandom));
                send_word(mode, 8'($urandom_range(0, 255)), 1'b1, 8'($urandom));
            end else begin
                send_string(mode, s, 8'($urandom));
            end
            sent += len;
            if (sent > items / 4 && sent - len <= items / 4)
                write_buffer_length(7'($urandom_range(3, 10)));
            if (sent > 3 * items / 4 && sent - len <= 3 * items / 4)
                write_buffer_length(7'd64);
        end
        steady = 1'b0;
    endtask

    // Fill the store until an insert no longer fits.
    task automatic test_store_full();
        string s;
        while (trie_used < NODE_COUNT - 4) begin
            s = random_word(8, 26);
            send_string(MODE_INSERT, s, 8'($urandom));
        end
        send_string(MODE_INSERT, "yyyyyyyy", 8'd2);
        send_string(MODE_INSERT, "wwww", 8'd3);
        send_string(MODE_LOOKUP, "go", 8'd0);
    endtask

    initial begin
        trie_used = 0;
        str_len = 0;
        str_bad = 1'b0;
        buf_limit = 64;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_buffer_length();
        test_random(100);
        test_store_full();
        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/tct_pkg.sv
hw/rtl/tct_datapath.sv
hw/rtl/tct_ctrl.sv
hw/rtl/trie_command_table.sv
hw/rtl/tct_checker.sv
verif/tb_trie_command_table.sv
